// ----- rtl/can_capture_record_fifo_macros.svh -----
// assertion macros for the can capture record fifo
// used by the top level only; expects clk and rst_n in scope
`ifndef CAN_CAPTURE_RECORD_FIFO_MACROS_SVH
`define CAN_CAPTURE_RECORD_FIFO_MACROS_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define CCRF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CCRF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CCRF_ASSERT(lbl, prop, msg)
`define CCRF_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- rtl/ccrf_pkg.sv -----
// shared types and constants of the can capture record fifo
// no dependencies
package ccrf_pkg;

    localparam int RING_DEPTH  = 16;
    localparam int PTR_W       = $clog2(RING_DEPTH);
    localparam int CNT_W       = $clog2(RING_DEPTH + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_INTERVAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_RECORDS   = 2'd2;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [7:0]  TAG_DROP        = 8'hAF;
    localparam logic [7:0]  TAG_FRAME       = 8'hA0;
    localparam logic [3:0]  DLC_MAX         = 4'd8;
    localparam logic [15:0] DROP_MAX        = 16'hFFFF;
    localparam logic [15:0] INTERVAL_RESET  = 16'd20;
    localparam logic [2:0]  BATCH_RESET     = 3'd4;
    localparam logic [2:0]  BATCH_MAX       = 3'd4;

    // one ring operation, front to back
    typedef struct packed {
        logic             is_read;
        logic [PTR_W-1:0] addr;
        logic [63:0]      lo;
        logic [63:0]      hi;
        logic             last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- rtl/ccrf_front.sv -----
// front part: config registers, item accept, ring bookkeeping, command issue
// depends on ccrf_pkg
module ccrf_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [ccrf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ccrf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             opcode,
    input  logic [31:0]                      time_ms,
    input  logic [28:0]                      can_id,
    input  logic [3:0]                       dlc,
    input  logic                             remote_frame,
    input  logic [63:0]                      data_bytes,
    input  logic                             host_ready,
    input  ccrf_pkg::q_stat_t                q_stat,
    output logic                             cmd_push,
    output ccrf_pkg::cmd_t                   cmd
);
    import ccrf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } st_t;

    st_t              st_reg, st_next;
    logic             en_reg, en_next;
    logic [15:0]      interval_reg, interval_next;
    logic [2:0]       batch_reg, batch_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [15:0]      drop_reg, drop_next;
    logic [31:0]      last_flush_reg, last_flush_next;
    logic             is_read_reg, is_read_next;
    logic [PTR_W-1:0] addr_reg, addr_next;
    logic [2:0]       left_reg, left_next;
    logic [63:0]      rec0_lo_reg, rec0_lo_next, rec0_hi_reg, rec0_hi_next;
    logic [63:0]      rec1_lo_reg, rec1_lo_next, rec1_hi_reg, rec1_hi_next;

    logic             accept;
    logic             frame_ok;
    logic [CNT_W:0]   fill_plus2;
    logic             drop_room;
    logic [CNT_W-1:0] fill_mid;
    logic             ring_full;
    logic [63:0]      drop_lo, frame_lo, frame_hi;
    logic [15:0]      drop_inc;
    logic [2:0]       batch_eff;
    logic [31:0]      elapsed;
    logic             do_flush;
    logic [CNT_W-1:0] to_end, n_min1, n_all, rp_sum;
    logic [2:0]       n_rec;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign accept   = in_valid && (st_reg == ST_IDLE);
    assign in_stall = (st_reg != ST_IDLE);

    // frame classification and record formatting
    always_comb
    begin
        frame_ok   = (dlc <= DLC_MAX) && !remote_frame;
        fill_plus2 = {1'b0, fill_reg} + (CNT_W + 1)'(2);
        drop_room  = (drop_reg != '0) && (fill_plus2 <= (CNT_W + 1)'(RING_DEPTH));
        fill_mid   = fill_reg + CNT_W'(drop_room);
        ring_full  = fill_mid >= CNT_W'(RING_DEPTH);
        drop_lo    = {16'h0000, drop_reg, time_ms[23:0], TAG_DROP};
        frame_lo   = {3'b000, can_id, time_ms[23:0], TAG_FRAME | {4'h0, dlc}};
        for (int i = 0; i < 8; i++)
        begin
            frame_hi[8*i +: 8] = (4'(i) < dlc) ? data_bytes[8*i +: 8] : 8'h00;
        end
        drop_inc = drop_room ? 16'h0000 : drop_reg;
        if (ring_full && (drop_inc != DROP_MAX))
        begin
            drop_inc = drop_inc + 16'd1;
        end
    end

    // flush decision and record count, never past the ring end
    always_comb
    begin
        if (batch_reg == 3'd0)
        begin
            batch_eff = 3'd1;
        end
        else if (batch_reg > BATCH_MAX)
        begin
            batch_eff = BATCH_MAX;
        end
        else
        begin
            batch_eff = batch_reg;
        end
        elapsed  = time_ms - last_flush_reg;
        do_flush = host_ready && (fill_reg != '0)
                   && ((fill_reg >= CNT_W'(batch_eff)) || (elapsed >= {16'h0000, interval_reg}));
        to_end   = CNT_W'(RING_DEPTH) - CNT_W'(rp_reg);
        n_min1   = (fill_reg < CNT_W'(batch_eff)) ? fill_reg : CNT_W'(batch_eff);
        n_all    = (n_min1 < to_end) ? n_min1 : to_end;
        n_rec    = n_all[2:0];
        rp_sum   = CNT_W'(rp_reg) + n_all;
    end

    always_comb
    begin
        st_next         = st_reg;
        en_next         = en_reg;
        interval_next   = interval_reg;
        batch_next      = batch_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        fill_next       = fill_reg;
        drop_next       = drop_reg;
        last_flush_next = last_flush_reg;
        is_read_next    = is_read_reg;
        addr_next       = addr_reg;
        left_next       = left_reg;
        rec0_lo_next    = rec0_lo_reg;
        rec0_hi_next    = rec0_hi_reg;
        rec1_lo_next    = rec1_lo_reg;
        rec1_hi_next    = rec1_hi_reg;
        cmd_push        = 1'b0;

        case (st_reg)
            ST_IDLE:
            begin
                if (accept && en_reg)
                begin
                    if (opcode == OP_FRAME)
                    begin
                        if (frame_ok)
                        begin
                            is_read_next = 1'b0;
                            addr_next    = wp_reg;
                            drop_next    = drop_inc;
                            rec1_lo_next = frame_lo;
                            rec1_hi_next = frame_hi;
                            if (drop_room)
                            begin
                                // drop report goes ahead of the frame
                                rec0_lo_next = drop_lo;
                                rec0_hi_next = 64'h0;
                                left_next    = 3'd2;
                                wp_next      = ptr_inc(ptr_inc(wp_reg));
                                fill_next    = fill_reg + CNT_W'(2);
                                st_next      = ST_EMIT;
                            end
                            else if (!ring_full)
                            begin
                                rec0_lo_next = frame_lo;
                                rec0_hi_next = frame_hi;
                                left_next    = 3'd1;
                                wp_next      = ptr_inc(wp_reg);
                                fill_next    = fill_reg + CNT_W'(1);
                                st_next      = ST_EMIT;
                            end
                        end
                    end
                    else if (do_flush)
                    begin
                        is_read_next    = 1'b1;
                        addr_next       = rp_reg;
                        left_next       = n_rec;
                        rp_next         = (rp_sum == CNT_W'(RING_DEPTH)) ? '0 : rp_sum[PTR_W-1:0];
                        fill_next       = fill_reg - n_all;
                        last_flush_next = time_ms;
                        st_next         = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!q_stat.full)
                begin
                    cmd_push     = 1'b1;
                    addr_next    = ptr_inc(addr_reg);
                    left_next    = left_reg - 3'd1;
                    rec0_lo_next = rec1_lo_reg;
                    rec0_hi_next = rec1_hi_reg;
                    if (left_reg == 3'd1)
                    begin
                        st_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase

        // the user must send register writes only while idle; this block does not enforce it
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CAPTURE_ENABLED:
                begin
                    en_next = cfg_data[0];
                    if (cfg_data[0] != en_reg)
                    begin
                        wp_next   = '0;
                        rp_next   = '0;
                        fill_next = '0;
                        drop_next = '0;
                    end
                end
                CFG_FLUSH_INTERVAL:
                begin
                    interval_next = cfg_data;
                end
                CFG_BATCH_RECORDS:
                begin
                    batch_next = cfg_data[2:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cmd.is_read = is_read_reg;
        cmd.addr    = addr_reg;
        cmd.lo      = rec0_lo_reg;
        cmd.hi      = rec0_hi_reg;
        cmd.last    = (left_reg == 3'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_IDLE;
            en_reg         <= 1'b0;
            interval_reg   <= INTERVAL_RESET;
            batch_reg      <= BATCH_RESET;
            wp_reg         <= '0;
            rp_reg         <= '0;
            fill_reg       <= '0;
            drop_reg       <= '0;
            last_flush_reg <= '0;
            is_read_reg    <= 1'b0;
            addr_reg       <= '0;
            left_reg       <= '0;
        end
        else
        begin
            st_reg         <= st_next;
            en_reg         <= en_next;
            interval_reg   <= interval_next;
            batch_reg      <= batch_next;
            wp_reg         <= wp_next;
            rp_reg         <= rp_next;
            fill_reg       <= fill_next;
            drop_reg       <= drop_next;
            last_flush_reg <= last_flush_next;
            is_read_reg    <= is_read_next;
            addr_reg       <= addr_next;
            left_reg       <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec0_lo_reg <= rec0_lo_next;
        rec0_hi_reg <= rec0_hi_next;
        rec1_lo_reg <= rec1_lo_next;
        rec1_hi_reg <= rec1_hi_next;
    end

endmodule

// ----- rtl/ccrf_cmd_queue.sv -----
// short command queue between front and back
// depends on ccrf_pkg
module ccrf_cmd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ccrf_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output ccrf_pkg::cmd_t    head,
    output ccrf_pkg::q_stat_t stat
);
    import ccrf_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign head       = entry_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/ccrf_back.sv -----
// back part: record ring memory, registered read, two-entry output buffer
// depends on ccrf_pkg
module ccrf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ccrf_pkg::q_stat_t q_stat,
    input  ccrf_pkg::cmd_t    head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [63:0]       record_low,
    output logic [63:0]       record_high,
    output logic              is_last
);
    import ccrf_pkg::*;

    localparam int OUT_DEPTH = 2;
    localparam int OB_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OB_CNT_W  = $clog2(OUT_DEPTH + 1);

    logic [127:0]        ring_mem [RING_DEPTH];
    logic [127:0]        rd_data_reg;
    logic                rd_last_reg;
    logic                rd_valid_reg, rd_valid_next;
    logic [127:0]        ob_data_reg [OUT_DEPTH];
    logic                ob_last_reg [OUT_DEPTH];
    logic [OB_PTR_W-1:0] ob_wr_reg, ob_wr_next;
    logic [OB_PTR_W-1:0] ob_rd_reg, ob_rd_next;
    logic [OB_CNT_W-1:0] ob_cnt_reg, ob_cnt_next;
    logic                credit_ok;
    logic                out_pop;

    // a read issues only when the buffer has room for it and the one in flight
    assign credit_ok = ({1'b0, ob_cnt_reg} + (OB_CNT_W + 1)'(rd_valid_reg))
                       < (OB_CNT_W + 1)'(OUT_DEPTH);
    assign pop       = !q_stat.empty && (!head.is_read || credit_ok);
    assign out_valid = (ob_cnt_reg != '0);
    assign out_pop   = out_valid && !out_stall;

    assign record_low  = ob_data_reg[ob_rd_reg][63:0];
    assign record_high = ob_data_reg[ob_rd_reg][127:64];
    assign is_last     = ob_last_reg[ob_rd_reg];

    always_comb
    begin
        rd_valid_next = pop && head.is_read;
        ob_wr_next    = rd_valid_reg ? ob_wr_reg + 1'b1 : ob_wr_reg;
        ob_rd_next    = out_pop ? ob_rd_reg + 1'b1 : ob_rd_reg;
        ob_cnt_next   = ob_cnt_reg + OB_CNT_W'(rd_valid_reg) - OB_CNT_W'(out_pop);
    end

    always_ff @(posedge clk)
    begin
        if (pop && !head.is_read)
        begin
            ring_mem[head.addr] <= {head.hi, head.lo};
        end
        if (pop && head.is_read)
        begin
            rd_data_reg <= ring_mem[head.addr];
            rd_last_reg <= head.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            ob_data_reg[ob_wr_reg] <= rd_data_reg;
            ob_last_reg[ob_wr_reg] <= rd_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            ob_wr_reg    <= '0;
            ob_rd_reg    <= '0;
            ob_cnt_reg   <= '0;
        end
        else
        begin
            rd_valid_reg <= rd_valid_next;
            ob_wr_reg    <= ob_wr_next;
            ob_rd_reg    <= ob_rd_next;
            ob_cnt_reg   <= ob_cnt_next;
        end
    end

endmodule

// ----- rtl/can_capture_record_fifo.sv -----
// can capture record fifo, top level
// depends on ccrf_pkg, ccrf_front, ccrf_cmd_queue, ccrf_back and the macro header

// Turns accepted CAN data frames into 16-byte capture records kept in a 16-entry
// ring, and sends them out on a flush poll. One item is taken at a time: a frame
// is accepted and then causes one ring write per record (none, one, or two when a
// drop record goes first); a flush poll is accepted and then causes one ring read
// per record sent (up to 4). The front issues one ring command per cycle into the
// command queue while the queue is not full. Records leave in order while
// out_stall is low; a ring read passes through a read register before it
// reaches the two-entry output buffer, and a read only issues when the buffer
// has room for it; a stalled output fills the output buffer and then the
// command queue, which in turn holds off new items. Remote frames and frames
// with dlc above 8 are dropped silently. With capture disabled, frames and
// polls are taken and ignored. Register writes (cfg_ready is always high) must
// only come while the block is idle; changing capture_enabled empties the ring.
// Nothing needs clearing after reset.

`include "can_capture_record_fifo_macros.svh"

module can_capture_record_fifo (
    input  logic                             clk,
    input  logic                             rst_n,
    // register write port
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ccrf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ccrf_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input items
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             opcode,
    input  logic [31:0]                      time_ms,
    input  logic [28:0]                      can_id,
    input  logic [3:0]                       dlc,
    input  logic                             remote_frame,
    input  logic [63:0]                      data_bytes,
    input  logic                             host_ready,
    // result items
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [63:0]                      record_low,
    output logic [63:0]                      record_high,
    output logic                             is_last
);
    import ccrf_pkg::*;

    cmd_t    push_cmd;
    cmd_t    head_cmd;
    logic    cmd_push;
    logic    q_pop;
    q_stat_t q_stat;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    // front: accept, classify, keep pointers and counters, issue ring commands
    ccrf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .time_ms      (time_ms),
        .can_id       (can_id),
        .dlc          (dlc),
        .remote_frame (remote_frame),
        .data_bytes   (data_bytes),
        .host_ready   (host_ready),
        .q_stat       (q_stat),
        .cmd_push     (cmd_push),
        .cmd          (push_cmd)
    );

    // in-order queue keeps ring writes ahead of the reads that follow them
    ccrf_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (head_cmd),
        .stat     (q_stat)
    );

    // back: ring memory writes, reads into the output buffer
    ccrf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .head        (head_cmd),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .record_low  (record_low),
        .record_high (record_high),
        .is_last     (is_last)
    );

    `CCRF_ASSERT(a_push_not_full, cmd_push |-> !q_stat.full, "command pushed into full queue")
    `CCRF_ASSERT(a_pop_not_empty, q_pop |-> !q_stat.empty, "command popped from empty queue")
    `CCRF_ASSERT(a_stall_while_issuing, cmd_push |-> in_stall, "item accepted while issuing commands")
    `CCRF_ASSERT_ALWAYS(a_quiet_after_reset, $rose(rst_n) |-> !out_valid, "result offered out of reset")

endmodule

// ----- verif/tb.sv -----
// self-checking bench for can_capture_record_fifo: drives frames and flush polls,
// predicts the flushed capture records and checks each one as it leaves the block
// depends on ccrf_pkg and the can_capture_record_fifo rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ccrf_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int unsigned SETTLE_CYCLES = 24;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned LOST_FRAMES   = 8;

    // one input item as seen on the ports
    typedef struct packed {
        logic        op;
        logic [31:0] stamp_ms;
        logic [28:0] id;
        logic [3:0]  len;
        logic        rtr;
        logic [63:0] payload;
        logic        ready;
    } capture_item_t;

    // one record leaving the block on a flush
    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic        last;
    } flush_record_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic          in_valid = 1'b0;
    logic          in_stall;
    capture_item_t drv_item = '0;
    logic          opcode;
    logic [31:0]   time_ms;
    logic [28:0]   can_id;
    logic [3:0]    dlc;
    logic          remote_frame;
    logic [63:0]   data_bytes;
    logic          host_ready;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] record_low;
    logic [63:0] record_high;
    logic        is_last;

    assign opcode       = drv_item.op;
    assign time_ms      = drv_item.stamp_ms;
    assign can_id       = drv_item.id;
    assign dlc          = drv_item.len;
    assign remote_frame = drv_item.rtr;
    assign data_bytes   = drv_item.payload;
    assign host_ready   = drv_item.ready;

    can_capture_record_fifo DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .time_ms      (time_ms),
        .can_id       (can_id),
        .dlc          (dlc),
        .remote_frame (remote_frame),
        .data_bytes   (data_bytes),
        .host_ready   (host_ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .record_low   (record_low),
        .record_high  (record_high),
        .is_last      (is_last)
    );

    always #4 clk = ~clk;

    // ---------------------------------------------------------------------
    // predicted copy of the capture state and registers
    // ---------------------------------------------------------------------
    logic [63:0]      ring_lo [RING_DEPTH];
    logic [63:0]      ring_hi [RING_DEPTH];
    logic [PTR_W-1:0] wr_ptr = '0;
    logic [PTR_W-1:0] rd_ptr = '0;
    int unsigned      fill_lvl = 0;
    logic [15:0]      drop_cnt = '0;
    logic [31:0]      last_flush_ms = '0;
    logic             cap_en = 1'b0;
    logic [15:0]      interval_ms = INTERVAL_RESET;
    logic [2:0]       batch_reg = BATCH_RESET;

    // records a flush has produced and the block has not yet sent
    flush_record_t flushed_records[$];
    // items waiting for the driver
    capture_item_t pending_items[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    logic [31:0] sim_ms = '0;

    // handoff between the sampling edge and the driving edge
    logic        item_taken = 1'b0;
    bit          no_idling = 1'b0;
    int unsigned hold_requests = 0;
    int unsigned holds_served = 0;

    function automatic void ring_store(logic [63:0] lo, logic [63:0] hi);
        ring_lo[wr_ptr] = lo;
        ring_hi[wr_ptr] = hi;
        wr_ptr = wr_ptr + 1'b1;
        fill_lvl = fill_lvl + 1;
    endfunction

    function automatic void empty_ring();
        wr_ptr = '0;
        rd_ptr = '0;
        fill_lvl = 0;
        drop_cnt = '0;
    endfunction

    function automatic void write_capture_reg(logic [CFG_IDX_W-1:0] idx,
                                              logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_CAPTURE_ENABLED:
            begin
                // a change of mode throws away whatever is buffered
                if (val[0] != cap_en)
                    empty_ring();
                cap_en = val[0];
            end
            CFG_FLUSH_INTERVAL: interval_ms = val;
            CFG_BATCH_RECORDS:  batch_reg = val[2:0];
            default: ;
        endcase
    endfunction

    function automatic void advance_capture(capture_item_t it);
        logic [63:0]  bytes_kept;
        logic [31:0]  since;
        int unsigned  batch;
        int unsigned  n;
        int unsigned  r;
        int unsigned  k;
        flush_record_t rec;
        if (!cap_en)
            return;
        if (it.op == OP_FRAME)
        begin
            if (it.len > DLC_MAX || it.rtr)
                return;
            // report losses first, but only when the frame behind it still fits
            if (drop_cnt != 0 && fill_lvl + 2 <= RING_DEPTH)
            begin
                ring_store({16'h0000, drop_cnt, it.stamp_ms[23:0], TAG_DROP}, 64'h0);
                drop_cnt = '0;
            end
            if (fill_lvl >= RING_DEPTH)
            begin
                if (drop_cnt != DROP_MAX)
                    drop_cnt = drop_cnt + 1'b1;
                return;
            end
            if (it.len >= DLC_MAX)
                bytes_kept = it.payload;
            else
                bytes_kept = it.payload & ((64'd1 << (it.len * 8)) - 64'd1);
            ring_store({3'b000, it.id, it.stamp_ms[23:0], TAG_FRAME | {4'h0, it.len}},
                       bytes_kept);
            return;
        end
        batch = batch_reg;
        if (batch == 0)
            batch = 1;
        if (batch > BATCH_MAX)
            batch = BATCH_MAX;
        if (!it.ready || fill_lvl == 0)
            return;
        since = it.stamp_ms - last_flush_ms;
        if (!(fill_lvl >= batch || since >= interval_ms))
            return;
        n = (fill_lvl < batch) ? fill_lvl : batch;
        r = rd_ptr;
        // a flush stops at the end of the ring
        if (n > RING_DEPTH - r)
            n = RING_DEPTH - r;
        for (k = 0; k < n; k++)
        begin
            rec.lo = ring_lo[r + k];
            rec.hi = ring_hi[r + k];
            rec.last = (k + 1 == n);
            flushed_records.push_back(rec);
        end
        rd_ptr = rd_ptr + n[PTR_W-1:0];
        fill_lvl = fill_lvl - n;
        last_flush_ms = it.stamp_ms;
    endfunction

    // ---------------------------------------------------------------------
    // item builders
    // ---------------------------------------------------------------------
    function automatic capture_item_t frame_at(logic [31:0] ms, logic [28:0] id,
                                               logic [3:0] len, logic rtr,
                                               logic [63:0] bytes);
        capture_item_t it;
        it = '0;
        it.op = OP_FRAME;
        it.stamp_ms = ms;
        it.id = id;
        it.len = len;
        it.rtr = rtr;
        it.payload = bytes;
        return it;
    endfunction

    function automatic capture_item_t poll_at(logic [31:0] ms, logic ready);
        capture_item_t it;
        it = '0;
        it.op = OP_FLUSH;
        it.stamp_ms = ms;
        it.ready = ready;
        return it;
    endfunction

    // well-formed frame with random content, time moving forward slowly
    function automatic capture_item_t good_frame();
        sim_ms = sim_ms + $urandom_range(0, 3);
        return frame_at(sim_ms, 29'($urandom()), 4'($urandom_range(0, 8)), 1'b0,
                        {$urandom(), $urandom()});
    endfunction

    function automatic capture_item_t random_item();
        capture_item_t it;
        int unsigned   roll;
        roll = $urandom_range(0, 99);
        // mostly small steps, sometimes past any interval, rarely anywhere
        if (roll < 3)
            sim_ms = $urandom();
        else if (roll < 10)
            sim_ms = sim_ms + $urandom_range(0, 70000);
        else
            sim_ms = sim_ms + $urandom_range(0, 9);
        it.op = ($urandom_range(0, 99) < 58) ? OP_FRAME : OP_FLUSH;
        it.stamp_ms = sim_ms;
        if ($urandom_range(0, 3) == 0)
            it.id = 29'($urandom_range(0, 2047));
        else
            it.id = 29'($urandom());
        if ($urandom_range(0, 9) == 0)
            it.len = 4'($urandom_range(9, 15));
        else
            it.len = 4'($urandom_range(0, 8));
        it.rtr = ($urandom_range(0, 19) == 0);
        it.payload = {$urandom(), $urandom()};
        it.ready = ($urandom_range(0, 6) != 0);
        return it;
    endfunction

    // ---------------------------------------------------------------------
    // sampling edge: register writes, accepted items, checked records
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        flush_record_t want;
        item_taken = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                write_capture_reg(cfg_index, cfg_data);
            // predict before checking so a same-edge record still finds its entry
            if (in_valid && !in_stall)
            begin
                advance_capture(drv_item);
                item_taken = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                if (flushed_records.size() == 0)
                begin
                    $display("%0t unexpected record: low %h high %h last %b",
                             $time, record_low, record_high, is_last);
                    mismatch_count++;
                end
                else
                begin
                    want = flushed_records.pop_front();
                    if (record_low !== want.lo)
                    begin
                        $display("%0t record_low expected %h actual %h",
                                 $time, want.lo, record_low);
                        mismatch_count++;
                    end
                    if (record_high !== want.hi)
                    begin
                        $display("%0t record_high expected %h actual %h",
                                 $time, want.hi, record_high);
                        mismatch_count++;
                    end
                    if (is_last !== want.last)
                    begin
                        $display("%0t is_last expected %b actual %b",
                                 $time, want.last, is_last);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // item driver: holds a stalled item, otherwise idles in bursts or sends the next
    // ---------------------------------------------------------------------
    int unsigned send_gap = 0;

    always @(negedge clk)
    begin : driver
        if (in_valid && !item_taken)
            ; // still waiting to be taken
        else if (send_gap > 0)
        begin
            send_gap--;
            in_valid <= 1'b0;
        end
        else if (pending_items.size() > 0)
        begin
            drv_item <= pending_items.pop_front();
            in_valid <= 1'b1;
            if (!no_idling && $urandom_range(0, 7) == 0)
                send_gap = $urandom_range(1, 19);
        end
        else
            in_valid <= 1'b0;
    end

    // ---------------------------------------------------------------------
    // result receiver: random stall bursts plus an occasional long hold-off
    // ---------------------------------------------------------------------
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;

    always @(negedge clk)
    begin : receiver
        if (hold_requests != holds_served)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!no_idling && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 19) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // watchdog against a hung block
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // all items taken, all records seen, then a margin for frames still in flight
    task automatic wait_idle();
        @(negedge clk);
        while (pending_items.size() != 0 || in_valid || flushed_records.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic random_phase(input logic [2:0] batch, input logic [15:0] interval,
                                input int unsigned count, input bit long_hold);
        logic [15:0] word;
        int unsigned k;
        // junk above the batch field must be ignored
        word = 16'($urandom());
        word[2:0] = batch;
        write_reg(CFG_BATCH_RECORDS, word);
        write_reg(CFG_FLUSH_INTERVAL, interval);
        if (long_hold)
            hold_requests++;
        for (k = 0; k < count; k++)
            pending_items.push_back(random_item());
        wait_idle();
    endtask

    // ---------------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned k;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // capture is off after reset: both kinds of item are swallowed
        pending_items.push_back(frame_at(32'd5, 29'h7FF, 4'd8, 1'b0, '1));
        pending_items.push_back(poll_at(32'd500, 1'b1));
        wait_idle();

        write_reg(CFG_CAPTURE_ENABLED, 16'h8001);
        write_reg(CFG_FLUSH_INTERVAL, 16'd20);
        write_reg(CFG_BATCH_RECORDS, {13'h0, BATCH_RESET});

        // directed: field extremes, discarded frames, flush conditions
        pending_items.push_back(poll_at(32'd0, 1'b1));                      // empty ring
        pending_items.push_back(frame_at(32'd1, 29'h0, 4'd0, 1'b0, '1));    // no payload
        pending_items.push_back(frame_at(32'hFFFF_FFFF, 29'h1FFF_FFFF, 4'd8, 1'b0, '1));
        pending_items.push_back(frame_at(32'd3, 29'h155, 4'd9, 1'b0, '1));  // dlc too big
        pending_items.push_back(frame_at(32'd3, 29'h155, 4'd15, 1'b0, '1));
        pending_items.push_back(frame_at(32'd4, 29'h0AA, 4'd4, 1'b1, '1));  // remote
        pending_items.push_back(frame_at(32'd5, 29'h123, 4'd3, 1'b0,
                                         64'hFEDC_BA98_7654_3210));         // masked tail
        pending_items.push_back(poll_at(32'h8000_0000, 1'b0));              // host away
        pending_items.push_back(poll_at(32'd10, 1'b1));                     // too early
        pending_items.push_back(poll_at(32'd20, 1'b1));                     // interval met
        pending_items.push_back(frame_at(32'd25, 29'h1, 4'd1, 1'b0, 64'h1111_2222_3333_4444));
        pending_items.push_back(frame_at(32'd25, 29'h2, 4'd2, 1'b0, 64'h5555_6666_7777_8888));
        pending_items.push_back(frame_at(32'd25, 29'h3, 4'd5, 1'b0, 64'h9999_AAAA_BBBB_CCCC));
        pending_items.push_back(frame_at(32'd25, 29'h4, 4'd6, 1'b0, 64'hDDDD_EEEE_FFFF_0000));
        pending_items.push_back(frame_at(32'd25, 29'h5, 4'd7, 1'b0, 64'h0123_4567_89AB_CDEF));
        pending_items.push_back(poll_at(32'd26, 1'b1));                     // batch full
        pending_items.push_back(poll_at(32'd27, 1'b1));                     // partial, early
        pending_items.push_back(poll_at(32'd100, 1'b1));                    // partial, late
        wait_idle();
        sim_ms = 32'd100;

        // overflow: fill the ring, lose a few frames, then let room return;
        // batch field 0 behaves as one record per flush
        no_idling = 1'b1;
        write_reg(CFG_BATCH_RECORDS, 16'd0);
        for (k = 0; k < RING_DEPTH + LOST_FRAMES; k++)
            pending_items.push_back(good_frame());
        pending_items.push_back(poll_at(sim_ms, 1'b1));   // one slot free
        pending_items.push_back(good_frame());            // fits, no loss record yet
        pending_items.push_back(good_frame());            // lost again
        pending_items.push_back(poll_at(sim_ms, 1'b1));
        pending_items.push_back(poll_at(sim_ms, 1'b1));   // two slots free
        pending_items.push_back(good_frame());            // loss record then frame
        for (k = 0; k < RING_DEPTH; k++)
            pending_items.push_back(poll_at(sim_ms, 1'b1));
        wait_idle();
        no_idling = 1'b0;

        // random traffic under a range of settings
        random_phase(3'd4, 16'd20, 60, 1'b0);
        random_phase(3'd1, 16'd0, 60, 1'b0);
        write_reg(CFG_CAPTURE_ENABLED, 16'h0003);          // same mode, ring kept
        random_phase(3'd7, 16'hFFFF, 60, 1'b0);

        // capture off empties the ring; items meanwhile are ignored
        write_reg(CFG_CAPTURE_ENABLED, 16'hFFFE);
        for (k = 0; k < 10; k++)
            pending_items.push_back(random_item());
        wait_idle();
        write_reg(CFG_CAPTURE_ENABLED, 16'h0001);
        random_phase(3'd2, 16'd5, 60, 1'b0);

        // receiver holds off long enough for the block to back up into its input
        random_phase(3'd4, 16'd0, 60, 1'b1);

        // millisecond counter wrapping between flushes
        sim_ms = 32'hFFFF_FFC0;
        random_phase(3'd3, 16'd100, 60, 1'b0);
        random_phase(3'd5, 16'd1, 60, 1'b0);

        // closing stretch at full speed on both sides
        no_idling = 1'b1;
        random_phase(3'd6, 16'd0, 60, 1'b0);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- can_capture_record_fifo.f -----
+incdir+rtl
rtl/ccrf_pkg.sv
rtl/ccrf_front.sv
rtl/ccrf_cmd_queue.sv
rtl/ccrf_back.sv
rtl/can_capture_record_fifo.sv
verif/tb.sv
